FILE: sv/assert_macros.svh
// assertion macros used by the colour map rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/plcm_pkg.sv
// shared types, constants and helpers of the piecewise linear colour map
`timescale 1ns / 1ps

package plcm_pkg;

  // field widths
  localparam int VALUE_W      = 16;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int WEIGHT_W     = 16;
  localparam int PROD_W       = WEIGHT_W + CHAN_W;

  // colour stops
  localparam int MAX_STOPS         = 4;
  localparam int NUM_STOPS_DEFAULT = 4;

  // configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = COLOR_W;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_VALUE_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_COLOR_BASE = 3'd4;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [CHAN_W-1:0]         chan_t;
  typedef logic [WEIGHT_W-1:0]       weight_t;
  typedef logic [PROD_W-1:0]         prod_t;

  // register values after reset
  localparam value_t STOP_VALUE_RESET [MAX_STOPS] = '{
    16'h8000, 16'hC000, 16'h4000, 16'h7FFF
  };
  localparam color_t STOP_COLOR_RESET [MAX_STOPS] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'hFFFFFF
  };

  // channel c of a packed colour, red first
  function automatic chan_t chan_of(input color_t color, input int c);
    return color[COLOR_W-1-CHAN_W*c -: CHAN_W];
  endfunction

endpackage

FILE: sv/piecewise_linear_color_map_top.sv
// Piecewise linear colour map: each signed sample becomes an RGB pixel blended between
// NUM_STOPS programmable colour stops. One item is taken every clock while the output is not
// stalled. The pipeline is the input, segment select, multiply and sum stages, then the
// restoring divider, one quotient bit per stage over eight stages. Each stage holds its
// item while the next one is full, so bubbles close up and a stall at the output loses
// nothing. The user must write stop registers through the cfg port only while no item is
// in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_linear_color_map_top
  import plcm_pkg::*;
#(
  parameter int NUM_STOPS = NUM_STOPS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // sample input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     sample_value,
  // pixel output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);

  // pipeline stage positions
  localparam int QUOT_W   = CHAN_W;
  localparam int ST_IN    = 0;
  localparam int ST_SEL   = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_DIV0  = 4;
  localparam int NUM_PIPE = ST_DIV0 + QUOT_W;
  localparam int ST_OUT   = NUM_PIPE - 1;

  // stop registers
  value_t stop_value [NUM_STOPS];
  color_t stop_color [NUM_STOPS];

  // handshake of the stages
  logic [NUM_PIPE-1:0] pipe_valid;
  logic [NUM_PIPE-1:0] stage_ready;

  // stage payloads
  value_t  smp;
  weight_t sel_wl, sel_wr, sel_den;
  color_t  sel_ca, sel_cb;
  weight_t sel_wl_next, sel_wr_next, sel_den_next;
  color_t  sel_ca_next, sel_cb_next;
  prod_t   mul_l [NUM_CHANNELS];
  prod_t   mul_r [NUM_CHANNELS];
  weight_t mul_den;
  prod_t   sum_num [NUM_CHANNELS];
  weight_t sum_den;
  prod_t   div_rem [QUOT_W][NUM_CHANNELS];
  chan_t   div_q   [QUOT_W][NUM_CHANNELS];
  weight_t div_den [QUOT_W];

  // segment search
  logic               seg_found;
  value_t             seg_s0, seg_s1;
  color_t             seg_ca, seg_cb;
  logic signed [16:0] diff_l, diff_r, diff_d;

  // configuration writes, unused stop indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        stop_value[k] <= STOP_VALUE_RESET[k];
        stop_color[k] <= STOP_COLOR_RESET[k];
      end
    end else if (cfg_write) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        if (cfg_index == REG_STOP_VALUE_BASE + CFG_INDEX_W'(k)) begin
          stop_value[k] <= cfg_data[VALUE_W-1:0];
        end
        if (cfg_index == REG_STOP_COLOR_BASE + CFG_INDEX_W'(k)) begin
          stop_color[k] <= cfg_data[COLOR_W-1:0];
        end
      end
    end
  end

  // a stage takes a new item when empty or when its successor moves
  always_comb begin
    stage_ready[ST_OUT] = !pipe_valid[ST_OUT] || out_ready;
    for (int i = 0; i < ST_OUT; i++) begin
      stage_ready[i] = !pipe_valid[i] || stage_ready[i+1];
    end
  end

  assign in_ready  = stage_ready[ST_IN];
  assign out_valid = pipe_valid[ST_OUT];

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else begin
      if (stage_ready[ST_IN]) begin
        pipe_valid[ST_IN] <= in_valid;
      end
      for (int i = 1; i < NUM_PIPE; i++) begin
        if (stage_ready[i]) begin
          pipe_valid[i] <= pipe_valid[i-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (stage_ready[ST_IN]) begin
      smp <= sample_value;
    end
  end

  // find the first segment that holds the sample
  always_comb begin
    seg_found = 1'b0;
    seg_s0    = stop_value[0];
    seg_s1    = stop_value[0];
    seg_ca    = stop_color[0];
    seg_cb    = stop_color[0];
    for (int k = 0; k < NUM_STOPS - 1; k++) begin
      if (!seg_found && stop_value[k] <= smp && smp <= stop_value[k+1]) begin
        seg_found = 1'b1;
        seg_s0    = stop_value[k];
        seg_s1    = stop_value[k+1];
        seg_ca    = stop_color[k];
        seg_cb    = stop_color[k+1];
      end
    end
  end

  // blend weights; a fixed colour goes through as weight one over one
  always_comb begin
    diff_l       = 17'(seg_s1) - 17'(smp);
    diff_r       = 17'(smp) - 17'(seg_s0);
    diff_d       = 17'(seg_s1) - 17'(seg_s0);
    sel_wl_next  = weight_t'(1);
    sel_wr_next  = '0;
    sel_den_next = weight_t'(1);
    sel_cb_next  = '0;
    if (smp <= stop_value[0]) begin
      sel_ca_next = stop_color[0];
    end else if (smp >= stop_value[NUM_STOPS-1]) begin
      sel_ca_next = stop_color[NUM_STOPS-1];
    end else if (!seg_found || diff_d == '0) begin
      // zero-width segment takes its left colour; with no segment found, the colour of stop 0
      sel_ca_next = seg_ca;
    end else begin
      sel_ca_next  = seg_ca;
      sel_cb_next  = seg_cb;
      sel_wl_next  = diff_l[WEIGHT_W-1:0];
      sel_wr_next  = diff_r[WEIGHT_W-1:0];
      sel_den_next = diff_d[WEIGHT_W-1:0];
    end
  end

  // segment select register
  always_ff @(posedge clk) begin
    if (stage_ready[ST_SEL]) begin
      sel_wl  <= sel_wl_next;
      sel_wr  <= sel_wr_next;
      sel_den <= sel_den_next;
      sel_ca  <= sel_ca_next;
      sel_cb  <= sel_cb_next;
    end
  end

  // weight times channel, two products per channel
  always_ff @(posedge clk) begin
    if (stage_ready[ST_MUL]) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        mul_l[c] <= prod_t'(sel_wl) * prod_t'(chan_of(sel_ca, c));
        mul_r[c] <= prod_t'(sel_wr) * prod_t'(chan_of(sel_cb, c));
      end
      mul_den <= sel_den;
    end
  end

  // numerators, bounded by den times 255 so they fit the product width
  always_ff @(posedge clk) begin
    if (stage_ready[ST_SUM]) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_num[c] <= PROD_W'({1'b0, mul_l[c]} + {1'b0, mul_r[c]});
      end
      sum_den <= mul_den;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int BIT = QUOT_W - 1 - j;
    prod_t   rem_in  [NUM_CHANNELS];
    chan_t   q_in    [NUM_CHANNELS];
    prod_t   rem_out [NUM_CHANNELS];
    chan_t   q_out   [NUM_CHANNELS];
    weight_t den_in;
    prod_t   trial;

    // first stage reads the sum stage, the others their predecessor
    if (j == 0) begin : g_head
      always_comb begin
        den_in = sum_den;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          rem_in[c] = sum_num[c];
          q_in[c]   = '0;
        end
      end
    end else begin : g_tail
      always_comb begin
        den_in = div_den[j-1];
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          rem_in[c] = div_rem[j-1][c];
          q_in[c]   = div_q[j-1][c];
        end
      end
    end

    always_comb begin
      trial = prod_t'(den_in) << BIT;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rem_out[c] = rem_in[c];
        q_out[c]   = q_in[c];
        if (rem_in[c] >= trial) begin
          rem_out[c]    = rem_in[c] - trial;
          q_out[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[ST_DIV0+j]) begin
        div_den[j] <= den_in;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          div_rem[j][c] <= rem_out[c];
          div_q[j][c]   <= q_out[c];
        end
      end
    end
  end

  // last divider stage is the output register
  assign red   = div_q[QUOT_W-1][0];
  assign green = div_q[QUOT_W-1][1];
  assign blue  = div_q[QUOT_W-1][2];

  // checks
  `ASSERT_IMPLIES(a_no_stuck_bubble, clk, rst, !pipe_valid[ST_OUT], in_ready,
    "input blocked while the output stage is empty")
  `ASSERT_IMPLIES(a_weights_sum, clk, rst, pipe_valid[ST_SEL],
    (17'(sel_wl) + 17'(sel_wr) == 17'(sel_den)), "blend weights do not add up to the span")
  `ASSERT_IMPLIES(a_nonzero_den, clk, rst, pipe_valid[ST_SEL], (sel_den != '0),
    "zero divisor reached the blend")
  `ASSERT_IMPLIES(a_quotient_fits, clk, rst, pipe_valid[ST_OUT],
    ((div_rem[QUOT_W-1][0] < prod_t'(div_den[QUOT_W-1])) &&
     (div_rem[QUOT_W-1][1] < prod_t'(div_den[QUOT_W-1])) &&
     (div_rem[QUOT_W-1][2] < prod_t'(div_den[QUOT_W-1]))),
    "divider remainder not below divisor")
  `ASSERT_ALWAYS(a_item_count, clk, rst,
    ($past(rst) || ($countones(pipe_valid) == $countones($past(pipe_valid)) +
      int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))),
    "items lost or duplicated in the pipeline")

endmodule

FILE: sim/piecewise_linear_color_map_top_test.sv
// self-checking testbench of the piecewise linear colour map: directed table, then random phases
`timescale 1ns / 1ps

module piecewise_linear_color_map_top_test;
  import plcm_pkg::*;

  localparam int NUM_STOPS   = NUM_STOPS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;

  // one pixel, packed the same way as a stop colour
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct {
    value_t sample;
    pixel_t pixel;
  } pending_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // word holds the sample in its low bits, or the register data
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   word;
    logic                    typed;
    color_t                  want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [15:0]     sample_value;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;

  // own copy of the stop registers
  value_t map_value [MAX_STOPS];
  color_t map_color [MAX_STOPS];

  pending_t pending_pixels [$];
  int       errors = 0;
  int       quiet_cycles = 0;
  int       sender_idle_pct;
  int       receiver_stall_pct;

  // directed table: reset map, recoloured map, zero-width segment,
  // stops out of order, widest segment
  stim_row_t directed_rows [37] = '{
    '{ROW_SAMPLE, 3'd0, 24'h008000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h007FFF, 1'b1, 24'hFFFFFF},
    '{ROW_SAMPLE, 3'd0, 24'h008001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h007FFE, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h00C000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h00C001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h00FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h004000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h004001, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_COLOR_BASE,        24'hFFFFFF, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_COLOR_BASE + 3'd1, 24'hFF00FF, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_COLOR_BASE + 3'd2, 24'h00FFFF, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_COLOR_BASE + 3'd3, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h008000, 1'b1, 24'hFFFFFF},
    '{ROW_SAMPLE, 3'd0, 24'h007FFF, 1'b1, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000064, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd1, 24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd2, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h00FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000001, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE,        24'h0003E8, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd1, 24'h00F830, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd2, 24'h0001F4, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd3, 24'h000BB8, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h0003E8, 1'b1, 24'hFFFFFF},
    '{ROW_SAMPLE, 3'd0, 24'h0003E9, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000BB7, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000BB8, 1'b1, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE,        24'h008000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd1, 24'h008000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd2, 24'h007FFF, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_STOP_VALUE_BASE + 3'd3, 24'h007FFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h008001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, 3'd0, 24'h007FFE, 1'b0, 24'h000000}
  };

  piecewise_linear_color_map_top #(
    .NUM_STOPS(NUM_STOPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_value(sample_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // colour of a sample under the current stop map
  function automatic pixel_t blend_pixel(input value_t v);
    color_t mix;
    longint lo_s, hi_s, span, a, b;
    int     k, c;
    if (v <= map_value[0]) return pixel_t'(map_color[0]);
    if (v >= map_value[NUM_STOPS-1]) return pixel_t'(map_color[NUM_STOPS-1]);
    // first segment holding the sample wins
    for (k = 0; k < NUM_STOPS - 1; k++) begin
      lo_s = longint'(map_value[k]);
      hi_s = longint'(map_value[k+1]);
      if (lo_s <= longint'(v) && longint'(v) <= hi_s) begin
        span = hi_s - lo_s;
        // zero-width segment gives the left colour
        if (span == 0) return pixel_t'(map_color[k]);
        for (c = 0; c < 3; c++) begin
          a = longint'(map_color[k][8*c +: 8]);
          b = longint'(map_color[k+1][8*c +: 8]);
          mix[8*c +: 8] = 8'(((hi_s - longint'(v)) * a + (longint'(v) - lo_s) * b) / span);
        end
        return pixel_t'(mix);
      end
    end
    return pixel_t'(map_color[0]);
  endfunction

  // one register write, mirrored into the local stop map
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx >= REG_STOP_COLOR_BASE) begin
      map_color[idx - REG_STOP_COLOR_BASE] = data;
    end else begin
      map_value[idx - REG_STOP_VALUE_BASE] = value_t'(data[VALUE_W-1:0]);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // present one item, optionally after idle cycles, and log its pixel on acceptance
  task automatic send_sample(input value_t v, input logic typed, input pixel_t want);
    pending_t entry;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entry.sample = v;
    entry.pixel  = typed ? want : blend_pixel(v);
    pending_pixels.push_back(entry);
  endtask

  // stop sending and wait until every pixel in flight has come out
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_channel(input string name, input value_t v,
                               input chan_t want, input chan_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: sample %0d %s expected %0d got %0d", $time, v, name, want, got);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // output checker
  always @(posedge clk) begin
    pending_t head;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel %0d/%0d/%0d with none expected", $time, red, green, blue);
      end else begin
        head = pending_pixels.pop_front();
        check_channel("red", head.sample, head.pixel.red, red);
        check_channel("green", head.sample, head.pixel.green, green);
        check_channel("blue", head.sample, head.pixel.blue, blue);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    int     phase, n, k, j, pause_at, pick;
    value_t stops [MAX_STOPS];
    color_t hues [MAX_STOPS];
    value_t swap_v, next_sample;

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_valid           = 1'b0;
    sample_value       = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    // register values after reset
    map_value[0] = -16'sd32768;
    map_value[1] = -16'sd16384;
    map_value[2] = 16'sd16384;
    map_value[3] = 16'sd32767;
    map_color[0] = 24'h000000;
    map_color[1] = 24'h0000FF;
    map_color[2] = 24'h00FF00;
    map_color[3] = 24'hFFFFFF;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_pixels();
        write_reg(directed_rows[i].index, directed_rows[i].word);
      end else begin
        send_sample(value_t'(directed_rows[i].word[VALUE_W-1:0]), directed_rows[i].typed,
                    pixel_t'(directed_rows[i].want));
      end
    end

    // random phases, each with its own stop map and idling pattern
    for (phase = 0; phase < PHASES; phase++) begin
      drain_pixels();

      for (k = 0; k < NUM_STOPS; k++) begin
        stops[k] = value_t'($urandom);
        hues[k]  = color_t'($urandom);
      end
      case (phase % 6)
        1: begin
          // full-range map with extreme colours at the ends
          stops[0] = -16'sd32768;
          stops[NUM_STOPS-1] = 16'sd32767;
          hues[0] = 24'h000000;
          hues[NUM_STOPS-1] = 24'hFFFFFF;
        end
        3: begin
          // tightly packed stops, zero-width segments likely
          for (k = 1; k < NUM_STOPS; k++) begin
            stops[k] = stops[k-1] + value_t'($urandom_range(3));
          end
        end
        5: begin
          stops[0] = -16'sd32768;
          stops[1] = -16'sd16384;
          stops[2] = 16'sd16384;
          stops[3] = 16'sd32767;
        end
        default: ;
      endcase
      // ascending order except for the out-of-order and packed maps
      if (phase % 6 != 2 && phase % 6 != 3) begin
        for (k = 0; k < NUM_STOPS - 1; k++) begin
          for (j = 0; j < NUM_STOPS - 1 - k; j++) begin
            if (stops[j] > stops[j+1]) begin
              swap_v     = stops[j];
              stops[j]   = stops[j+1];
              stops[j+1] = swap_v;
            end
          end
        end
      end
      // repeated stop value
      if (phase % 6 == 4) begin
        j = $urandom_range(NUM_STOPS - 2);
        stops[j+1] = stops[j];
      end

      for (k = 0; k < NUM_STOPS; k++) begin
        write_reg(CFG_INDEX_W'(REG_STOP_VALUE_BASE + k), {8'($urandom), stops[k]});
        write_reg(CFG_INDEX_W'(REG_STOP_COLOR_BASE + k), hues[k]);
      end

      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 67;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 67;
        end
        default: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
      endcase

      pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off until the pipeline is empty
        if (n == pause_at) drain_pixels();
        pick = $urandom_range(3);
        case (pick)
          0: begin
            // close to one of the stops
            j = $urandom_range(NUM_STOPS - 1);
            next_sample = map_value[j] + value_t'($urandom_range(8)) - 16'sd4;
          end
          1: next_sample = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
          default: next_sample = value_t'($urandom);
        endcase
        send_sample(next_sample, 1'b0, '0);
      end
    end

    drain_pixels();
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: piecewise_linear_color_map_top.f
+incdir+sv
sv/plcm_pkg.sv
sv/piecewise_linear_color_map_top.sv
sim/piecewise_linear_color_map_top_test.sv
